[hw/rtl/bracket_pair_matcher_unit_defines.svh]
// Assertion macros used by the bracket pair matcher datapath.
`ifndef BRACKET_PAIR_MATCHER_UNIT_DEFINES_SVH
`define BRACKET_PAIR_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define BPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define BPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bpm_pkg.sv]
// Types, character codes and report codes of the bracket pair matcher.
package bpm_pkg;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    localparam int OUT_POS_W = 16;

    localparam logic [2:0] KIND_PAIR_ROUND      = 3'd0;
    localparam logic [2:0] KIND_PAIR_SQUARE     = 3'd1;
    localparam logic [2:0] KIND_UNMATCHED_OPEN  = 3'd2;
    localparam logic [2:0] KIND_UNMATCHED_CLOSE = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW        = 3'd4;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           report_kind;
        logic                 is_square;
        logic [OUT_POS_W-1:0] open_position;
        logic [OUT_POS_W-1:0] close_position;
        logic                 run_last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        OPEN_ZERO,
        OPEN_TOP,
        OPEN_CUR
    } t_open_sel;

    typedef struct packed {
        logic       latch;
        logic       push;
        logic       pop;
        logic       emit;
        logic [2:0] kind;
        logic       sq;
        logic       sq_from_top;
        t_open_sel  open_sel;
        logic       run_last;
        logic       pos_step;
        logic       pos_clear;
    } t_cmd;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       count_zero;
        logic       count_one;
        logic       count_full;
        logic       top_square;
        logic       slot_free;
    } t_status;

endpackage

[hw/rtl/bpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bpm_ctrl.sv]
// Controller state machine of the bracket pair matcher.
module bpm_ctrl
    import bpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic finish;
        logic pushed;
        finish   = 1'b0;
        pushed   = 1'b0;
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.open_sel = OPEN_ZERO;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_status.sym)
                    CH_LPAREN, CH_LBRACK: begin
                        if (!i_status.count_full) begin
                            o_cmd.push = 1'b1;
                            pushed     = 1'b1;
                            finish     = 1'b1;
                        end else if (i_status.slot_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.kind     = KIND_OVERFLOW;
                            o_cmd.sq       = (i_status.sym == CH_LBRACK);
                            o_cmd.open_sel = OPEN_CUR;
                            o_cmd.run_last = !i_status.last;
                            finish         = 1'b1;
                        end
                    end
                    CH_RPAREN: begin
                        if (i_status.slot_free) begin
                            o_cmd.emit = 1'b1;
                            finish     = 1'b1;
                            if (!i_status.count_zero && !i_status.top_square) begin
                                o_cmd.kind     = KIND_PAIR_ROUND;
                                o_cmd.open_sel = OPEN_TOP;
                                o_cmd.pop      = 1'b1;
                                o_cmd.run_last = !i_status.last || i_status.count_one;
                            end else begin
                                o_cmd.kind     = KIND_UNMATCHED_CLOSE;
                                o_cmd.run_last = !i_status.last || i_status.count_zero;
                            end
                        end
                    end
                    CH_RBRACK: begin
                        if (i_status.slot_free) begin
                            o_cmd.emit = 1'b1;
                            if (!i_status.count_zero && !i_status.top_square) begin
                                // A round open above the nearest square one is dropped.
                                o_cmd.kind     = KIND_UNMATCHED_OPEN;
                                o_cmd.open_sel = OPEN_TOP;
                                o_cmd.pop      = 1'b1;
                            end else if (!i_status.count_zero) begin
                                o_cmd.kind     = KIND_PAIR_SQUARE;
                                o_cmd.sq       = 1'b1;
                                o_cmd.open_sel = OPEN_TOP;
                                o_cmd.pop      = 1'b1;
                                o_cmd.run_last = !i_status.last || i_status.count_one;
                                finish         = 1'b1;
                            end else begin
                                // The stack is empty here, so a flush adds nothing after it.
                                o_cmd.kind     = KIND_UNMATCHED_CLOSE;
                                o_cmd.sq       = 1'b1;
                                o_cmd.run_last = 1'b1;
                                finish         = 1'b1;
                            end
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_LOAD: begin
                // Lets the stack RAM read return the entry just pushed before the flush starts.
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_status.count_zero) begin
                    o_cmd.pos_clear = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.kind        = KIND_UNMATCHED_OPEN;
                    o_cmd.sq_from_top = 1'b1;
                    o_cmd.open_sel    = OPEN_TOP;
                    o_cmd.pop         = 1'b1;
                    o_cmd.run_last    = i_status.count_one;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            if (i_status.last) begin
                n_state = pushed ? S_LOAD : S_FLUSH;
            end else begin
                o_cmd.pos_step = 1'b1;
                n_state        = S_IDLE;
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[hw/rtl/bpm_dpath.sv]
// Datapath of the bracket pair matcher: stack, position counter and result register.
`include "bracket_pair_matcher_unit_defines.svh"
module bpm_dpath
    import bpm_pkg::*;
#(
    parameter int STACK_DEPTH   = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int EW    = POSITION_BITS + 1;
    localparam int EXT_W = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;

    logic [7:0]               r_sym;
    logic                     r_last;
    logic [POSITION_BITS-1:0] r_pos;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic [EW-1:0]            top;
    logic [AW-1:0]            raddr;
    logic [CW-1:0]            raddr_full;
    logic [EXT_W-1:0]         cur_ext;
    logic [EXT_W-1:0]         top_ext;
    logic [OUT_POS_W-1:0]     open_pos;
    logic                     slot_free;

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // The read address follows the top of the stack as it will stand after this edge.
    assign raddr_full = n_count - CW'(1);
    assign raddr      = raddr_full[AW-1:0];

    bpm_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_sym == CH_LBRACK, r_pos}),
        .i_raddr (raddr),
        .o_rdata (top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.pos_clear) begin
                r_pos <= '0;
            end else if (i_cmd.pos_step && r_pos != '1) begin
                r_pos <= r_pos + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sym  <= i_in_item.symbol;
            r_last <= i_in_item.end_of_text;
        end
    end

    assign slot_free = !r_out_valid || !i_out_stall;
    assign cur_ext   = EXT_W'(r_pos);
    assign top_ext   = EXT_W'(top[POSITION_BITS-1:0]);

    always_comb begin
        case (i_cmd.open_sel)
            OPEN_TOP: open_pos = top_ext[OUT_POS_W-1:0];
            OPEN_CUR: open_pos = cur_ext[OUT_POS_W-1:0];
            default:  open_pos = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.report_kind    <= i_cmd.kind;
            r_out.is_square      <= i_cmd.sq_from_top ? top[POSITION_BITS] : i_cmd.sq;
            r_out.open_position  <= open_pos;
            r_out.close_position <= cur_ext[OUT_POS_W-1:0];
            r_out.run_last       <= i_cmd.run_last;
        end
    end

    assign o_status.sym        = r_sym;
    assign o_status.last       = r_last;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.count_one  = (r_count == CW'(1));
    assign o_status.count_full = (r_count == CW'(STACK_DEPTH));
    assign o_status.top_square = top[POSITION_BITS];
    assign o_status.slot_free  = slot_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `BPM_ASSERT_IMP(a_emit_slot, i_cmd.emit, slot_free, "result issued into an occupied slot")
    `BPM_ASSERT_IMP(a_pop_nonempty, i_cmd.pop, r_count != '0, "pop from an empty stack")
    `BPM_ASSERT_IMP(a_push_room, i_cmd.push, r_count < CW'(STACK_DEPTH), "push onto a full stack")
    `BPM_ASSERT_NXT(a_push_count, i_cmd.push, r_count == $past(r_count) + CW'(1), "push lost")

endmodule

[hw/rtl/bracket_pair_matcher_unit.sv]
// Top level of the bracket pair matcher: controller, datapath and stack RAM.
// Latency: a result is presented the cycle after the execute or flush cycle that issues it.
// A new item is taken only once the last one is done: each is latched in idle, then
// worked in execute until all its results are given; end_of_text adds the flush of every
// open still stacked, after a load step for the stack RAM read when the item pushed.
// Reset is synchronous: the stack empties and the position returns to zero; entries are kept.
module bracket_pair_matcher_unit
    import bpm_pkg::*;
#(
    parameter int STACK_DEPTH   = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd    cmd;
    t_status status;

    // The controller walks each item through execute, and through the flush of
    // remaining opens when the item carries end_of_text.
    bpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the open-bracket stack, the character position and the
    // result register, which lets one result wait while the controller goes on.
    bpm_dpath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[tb/tb_bracket_pair_matcher_unit.sv]
// Self-checking testbench of the bracket pair matcher: directed table, random texts, predictor.
module tb_bracket_pair_matcher_unit
    import bpm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 32;
    localparam int POS_BITS    = 16;
    localparam int ITEM_TARGET = 480;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PRINT_LIMIT = 50;

    // One row of the directed table. A row repeats its item reps times; where
    // typed is set, the single result of that item is given by want.
    typedef struct packed {
        logic [7:0]  symbol;
        logic        eot;
        logic [31:0] reps;
        logic        typed;
        t_out_item   want;
    } t_step_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Predictor state: open brackets as {square, position}, their count and
    // the position of the next character.
    logic [POS_BITS:0]   open_mem [DEPTH];
    int                  open_count = 0;
    logic [POS_BITS-1:0] char_pos = '0;

    t_out_item expected_reports [$];
    t_out_item step_reports [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        counted_items = 0;
    bit        calm = 1'b0;

    t_step_row directed_rows [0:19] = '{
        // Closes on an empty stack are unmatched.
        '{CH_RPAREN, 1'b0, 32'd1, 1'b1, '{KIND_UNMATCHED_CLOSE, 1'b0, 16'd0, 16'd0, 1'b1}},
        '{CH_RBRACK, 1'b0, 32'd1, 1'b1, '{KIND_UNMATCHED_CLOSE, 1'b1, 16'd0, 16'd1, 1'b1}},
        // A ']' that drops a '(' above its '[', then the outer ')'.
        '{CH_LPAREN, 1'b0, 32'd1, 1'b0, '0},
        '{CH_LBRACK, 1'b0, 32'd1, 1'b0, '0},
        '{CH_LPAREN, 1'b0, 32'd1, 1'b0, '0},
        '{CH_RBRACK, 1'b0, 32'd1, 1'b0, '0},
        '{CH_RPAREN, 1'b0, 32'd1, 1'b0, '0},
        // Other characters take a position and give nothing.
        '{8'h00,     1'b0, 32'd1, 1'b0, '0},
        '{8'hFF,     1'b0, 32'd1, 1'b0, '0},
        // A pair closed by the final character.
        '{CH_LPAREN, 1'b0, 32'd1, 1'b0, '0},
        '{CH_RPAREN, 1'b1, 32'd1, 1'b0, '0},
        // Final character with nothing stacked.
        '{8'h61,     1'b1, 32'd1, 1'b0, '0},
        // Fill the stack, overflow once, then overflow and flush all of it.
        '{CH_LPAREN, 1'b0, 32'd32, 1'b0, '0},
        '{CH_LBRACK, 1'b0, 32'd1, 1'b1, '{KIND_OVERFLOW, 1'b1, 16'd32, 16'd32, 1'b1}},
        '{CH_LPAREN, 1'b1, 32'd1, 1'b0, '0},
        // A square open left over at the end.
        '{CH_LBRACK, 1'b0, 32'd1, 1'b0, '0},
        '{8'h7E,     1'b1, 32'd1, 1'b1, '{KIND_UNMATCHED_OPEN, 1'b1, 16'd0, 16'd1, 1'b1}},
        // A round pair, then a final ']' with nothing stacked.
        '{CH_LPAREN, 1'b0, 32'd1, 1'b0, '0},
        '{CH_RPAREN, 1'b0, 32'd1, 1'b1,
          '{KIND_PAIR_ROUND, 1'b0, 16'd0, 16'd1, 1'b1}},
        '{CH_RBRACK, 1'b1, 32'd1, 1'b1,
          '{KIND_UNMATCHED_CLOSE, 1'b1, 16'd0, 16'd2, 1'b1}}
    };

    bracket_pair_matcher_unit #(
        .STACK_DEPTH  (DEPTH),
        .POSITION_BITS(POS_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("** bracket_pair_matcher_unit: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic void add_report(input logic [2:0] kind, input logic sq,
                                       input logic [POS_BITS-1:0] open_at,
                                       input logic [POS_BITS-1:0] close_at);
        t_out_item r;
        r.report_kind    = kind;
        r.is_square      = sq;
        r.open_position  = open_at[OUT_POS_W-1:0];
        r.close_position = close_at[OUT_POS_W-1:0];
        r.run_last       = 1'b0;
        step_reports.push_back(r);
    endfunction

    // Works out the reports of one accepted item into step_reports and
    // advances the predictor state.
    function automatic void predict_reports(input t_in_item it);
        logic [POS_BITS-1:0] pos;
        logic                sq;
        step_reports.delete();
        pos = char_pos;
        if (it.symbol == CH_LPAREN || it.symbol == CH_LBRACK) begin
            sq = (it.symbol == CH_LBRACK);
            if (open_count >= DEPTH) begin
                add_report(KIND_OVERFLOW, sq, pos, pos);
            end else begin
                open_mem[open_count] = {sq, pos};
                open_count++;
            end
        end else if (it.symbol == CH_RPAREN) begin
            if (open_count > 0 && !open_mem[open_count-1][POS_BITS]) begin
                add_report(KIND_PAIR_ROUND, 1'b0, open_mem[open_count-1][POS_BITS-1:0], pos);
                open_count--;
            end else begin
                add_report(KIND_UNMATCHED_CLOSE, 1'b0, '0, pos);
            end
        end else if (it.symbol == CH_RBRACK) begin
            // Round opens above the nearest square one are given up first.
            while (open_count > 0 && !open_mem[open_count-1][POS_BITS]) begin
                add_report(KIND_UNMATCHED_OPEN, 1'b0, open_mem[open_count-1][POS_BITS-1:0], pos);
                open_count--;
            end
            if (open_count > 0) begin
                add_report(KIND_PAIR_SQUARE, 1'b1, open_mem[open_count-1][POS_BITS-1:0], pos);
                open_count--;
            end else begin
                add_report(KIND_UNMATCHED_CLOSE, 1'b1, '0, pos);
            end
        end
        if (it.end_of_text) begin
            while (open_count > 0) begin
                add_report(KIND_UNMATCHED_OPEN, open_mem[open_count-1][POS_BITS],
                           open_mem[open_count-1][POS_BITS-1:0], pos);
                open_count--;
            end
            char_pos = '0;
        end else if (char_pos != '1) begin
            char_pos = char_pos + 1'b1;
        end
        if (step_reports.size() > 0) begin
            step_reports[step_reports.size()-1].run_last = 1'b1;
        end
    endfunction

    // Presents one item from the falling edge on and returns at the rising
    // edge that takes it. Valid stays high into the next call when no gap
    // is drawn there.
    task automatic send_item(input logic [7:0] symbol, input logic eot,
                             input logic typed, input t_out_item want);
        t_in_item it;
        it.symbol      = symbol;
        it.end_of_text = eot;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 6) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do begin
            @(posedge clk);
        end while (in_stall);
        predict_reports(it);
        if (typed) begin
            expected_reports.push_back(want);
        end else begin
            foreach (step_reports[k]) expected_reports.push_back(step_reports[k]);
        end
        counted_items++;
        calm = (counted_items >= 150 && counted_items < 300);
    endtask

    // Random character of a bracket text: mostly brackets, some other codes.
    function automatic logic [7:0] text_symbol();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return CH_LPAREN;
        if (r < 50) return CH_LBRACK;
        if (r < 72) return CH_RPAREN;
        if (r < 90) return CH_RBRACK;
        return 8'($urandom_range(255));
    endfunction

    // The receiver stalls at random outside the calm stretch.
    always @(negedge clk) begin
        out_stall = !calm && ($urandom_range(99) < 6);
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report %p", out_item));
            end else begin
                want = expected_reports.pop_front();
                compare_field("report_kind", 32'(want.report_kind),
                              32'(out_item.report_kind));
                compare_field("is_square", 32'(want.is_square), 32'(out_item.is_square));
                compare_field("open_position", 32'(want.open_position),
                              32'(out_item.open_position));
                compare_field("close_position", 32'(want.close_position),
                              32'(out_item.close_position));
                compare_field("run_last", 32'(want.run_last), 32'(out_item.run_last));
            end
        end
    end

    initial begin
        int        len;
        int        deep;
        bit        noise;
        t_out_item none;
        none      = '0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            for (int n = 0; n < directed_rows[i].reps; n++) begin
                send_item(directed_rows[i].symbol, directed_rows[i].eot,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random texts; a bracket text is closed by an end-of-text item. A few start with a
        // deep run of opens to reach overflow; some are plain noise with end_of_text at random.
        while (counted_items < ITEM_TARGET) begin
            len   = $urandom_range(1, 40);
            noise = ($urandom_range(9) == 0);
            if ($urandom_range(11) == 0) begin
                deep = $urandom_range(28, 36);
                for (int n = 0; n < deep; n++) begin
                    send_item($urandom_range(1) ? CH_LBRACK : CH_LPAREN, 1'b0, 1'b0, none);
                end
            end
            for (int n = 0; n < len; n++) begin
                if (noise) begin
                    send_item(8'($urandom_range(255)), ($urandom_range(7) == 0), 1'b0, none);
                end else begin
                    send_item(text_symbol(), (n == len - 1), 1'b0, none);
                end
            end
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (expected_reports.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("** bracket_pair_matcher_unit: PASSED **");
        end else begin
            $display("** bracket_pair_matcher_unit: FAILED **");
        end
        $finish;
    end

endmodule
